// File: hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the schedule piece collector
// Holds the piece limit, register indexes, the held state record and the
// decoded input and result records passed between the step logic and top.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  // Largest schedule, in pieces; one bit per piece in the seen bitmap
  localparam int unsigned MAX_PIECES = 32;

  // Header field widths
  localparam int unsigned ID_W    = 32;
  localparam int unsigned REP_W   = 2;
  localparam int unsigned TOTAL_W = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CD_W    = 3;
  localparam int unsigned HOP_W   = 8;

  // Stream beat widths (padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_HOP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT = 8'd1;

  localparam logic [HOP_W-1:0] NODE_HOP_RST  = 8'd1;
  localparam logic [HOP_W-1:0] HOP_LIMIT_RST = 8'd8;

  // Countdown base: on completion countdown = ACT_BASE - repetition
  localparam logic [CD_W-1:0] ACT_BASE = 3'd4;

  // Collector state
  typedef struct packed {
    logic [CD_W-1:0]       countdown;
    logic                  held_valid;
    logic [ID_W-1:0]       held_id;
    logic [REP_W-1:0]      held_repeat;
    logic [TOTAL_W-1:0]    held_total;
    logic [MAX_PIECES-1:0] seen_map;
    logic [ID_W-1:0]       running_id;
    logic [ID_W-1:0]       expanded_id;
  } state_t;

  // One slot header
  typedef struct packed {
    logic                 timed_out;
    logic [ID_W-1:0]      sched_id;
    logic [REP_W-1:0]     repeat_no;
    logic [TOTAL_W-1:0]   piece_total;
    logic [IDX_W-1:0]     piece_index;
  } item_t;

  // One slot result
  typedef struct packed {
    logic             rebroadcast;
    logic             new_schedule;
    logic             piece_taken;
    logic             all_pieces;
    logic             replace_now;
    logic             expand_now;
    logic [ID_W-1:0]  active_id;
    logic [CD_W-1:0]  countdown_now;
    logic             bad_piece;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/spc_step.sv
// ----------------------------------------------------------------------------
// spc_step: per-slot update of the schedule piece collector
// Combinational: from the current state, the hop registers and one slot
// header, forms the next state and the result of the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_step (
  input  spc_pkg::state_t                state,
  input  spc_pkg::item_t                 item,
  input  logic [spc_pkg::HOP_W-1:0]      node_hop,
  input  logic [spc_pkg::HOP_W-1:0]      hop_limit,
  output spc_pkg::state_t                state_next,
  output spc_pkg::result_t               result
);
  import spc_pkg::*;

  logic                  decode;
  logic                  is_new;
  logic                  bad;
  logic                  fresh;
  logic                  taken;
  logic                  complete;
  logic                  repl;
  logic                  expd;
  logic [CD_W-1:0]       cd_dec;
  logic [MAX_PIECES-1:0] piece_bit;
  logic [MAX_PIECES:0]   mask_full;
  logic [MAX_PIECES-1:0] need;
  state_t                s1;

  // Countdown ticks down once per slot before anything else
  assign cd_dec = (state.countdown != '0) ? state.countdown - 1'b1 : state.countdown;

  assign decode = !item.timed_out && (node_hop < hop_limit);
  assign is_new = !state.held_valid || (item.sched_id != state.held_id);

  // Range check against the incoming count for a new id, else the held count
  always_comb begin
    if (is_new) begin
      bad = ({1'b0, item.piece_index} >= item.piece_total) ||
            (32'(item.piece_total) > MAX_PIECES);
    end else begin
      bad = ({1'b0, item.piece_index} >= state.held_total);
    end
  end

  assign piece_bit = MAX_PIECES'(1) << item.piece_index;

  // Header collection into the bitmap
  always_comb begin
    s1 = state;
    s1.countdown = cd_dec;
    fresh = 1'b0;
    taken = 1'b0;
    if (decode && !bad) begin
      if (is_new) begin
        s1.held_valid  = 1'b1;
        s1.held_id     = item.sched_id;
        s1.held_repeat = item.repeat_no;
        s1.held_total  = item.piece_total;
        s1.seen_map    = piece_bit;
        s1.countdown   = '0;
        fresh = 1'b1;
        taken = 1'b1;
      end else if ((item.repeat_no >= state.held_repeat) &&
                   ((state.seen_map & piece_bit) == '0)) begin
        s1.seen_map    = state.seen_map | piece_bit;
        s1.held_id     = item.sched_id;
        s1.held_repeat = item.repeat_no;
        taken = 1'b1;
      end
    end
  end

  // Completion: every piece below held_total seen
  assign mask_full = ((MAX_PIECES+1)'(1) << s1.held_total) - 1'b1;
  assign need      = mask_full[MAX_PIECES-1:0];
  assign complete  = s1.held_valid && ((s1.seen_map & need) == need);

  // Countdown reload and replacement
  always_comb begin
    state_next = s1;
    repl = 1'b0;
    expd = 1'b0;
    if (decode && !bad) begin
      if (complete) begin
        state_next.countdown = ACT_BASE - {1'b0, item.repeat_no};
      end
      if (state_next.countdown == CD_W'(1)) begin
        repl = 1'b1;
        state_next.running_id = s1.held_id;
        if (state.expanded_id != item.sched_id) begin
          expd = 1'b1;
          state_next.expanded_id = item.sched_id;
        end
      end
    end
  end

  // Slot result
  always_comb begin
    result.rebroadcast   = decode;
    result.new_schedule  = fresh;
    result.piece_taken   = taken;
    result.all_pieces    = complete;
    result.replace_now   = repl;
    result.expand_now    = expd;
    result.active_id     = state_next.running_id;
    result.countdown_now = state_next.countdown;
    result.bad_piece     = decode && bad;
  end

endmodule

`default_nettype wire

// File: hw/rtl/schedule_piece_collector.sv
// The result of each slot beat is registered in the output register when the slot beat is accepted.
// Throughput: one slot beat per cycle; the only limit is the output register,
// which takes a new beat whenever it is empty or is drained in the same cycle.
// Reset (rst, synchronous): no schedule held, countdown, bitmap and ids zero,
// node_hop = 1, hop_limit = 8, output register empty.
// ----------------------------------------------------------------------------
// schedule_piece_collector: collects schedule pieces per downlink slot
// Tracks the held schedule, its seen-piece bitmap and activation countdown,
// and reports rebroadcast, collection and replacement events per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module schedule_piece_collector (
  input  logic                               clk,
  input  logic                               rst,
  // slot beats
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] sched_id, [33:32] repeat_no, [39:34] piece_total,
  // [44:40] piece_index, [47:45] zero
  input  logic [spc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] timed_out
  input  logic                               s_axis_tuser,
  // result beats
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] rebroadcast, [1] new_schedule, [2] piece_taken, [3] all_pieces,
  // [4] replace_now, [5] expand_now, [37:6] active_id,
  // [40:38] countdown_now, [41] bad_piece, [47:42] zero
  output logic [spc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spc_pkg::HOP_W-1:0]          cfg_data
);
  import spc_pkg::*;

  state_t           state;
  state_t           state_next;
  item_t            item;
  result_t          result;
  result_t          out_res;
  logic [HOP_W-1:0] node_hop;
  logic [HOP_W-1:0] hop_limit;
  logic             in_fire;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Unpack the slot beat
  always_comb begin
    item.timed_out   = s_axis_tuser;
    item.sched_id    = s_axis_tdata[31:0];
    item.repeat_no   = s_axis_tdata[33:32];
    item.piece_total = s_axis_tdata[39:34];
    item.piece_index = s_axis_tdata[44:40];
  end

  spc_step u_step (
    .state      (state),
    .item       (item),
    .node_hop   (node_hop),
    .hop_limit  (hop_limit),
    .state_next (state_next),
    .result     (result)
  );

  // Hop registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_hop  <= NODE_HOP_RST;
      hop_limit <= HOP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NODE_HOP:  node_hop  <= cfg_data;
        REG_HOP_LIMIT: hop_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Collector state advances once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res <= result;
    end
  end

  // Pack the result beat
  assign m_axis_tdata = {6'd0,
                         out_res.bad_piece,
                         out_res.countdown_now,
                         out_res.active_id,
                         out_res.expand_now,
                         out_res.replace_now,
                         out_res.all_pieces,
                         out_res.piece_taken,
                         out_res.new_schedule,
                         out_res.rebroadcast};

endmodule

`default_nettype wire
